/* hdl/moe_rt_pkg.sv */
// Shared types and constants of the top-k softmax router.
// Holds the transaction structs, controller command/status structs and the 2^x table.
// Depends on nothing.
package moe_rt_pkg;

  localparam int CFG_W = 7;
  localparam int DIV_NUM_W = 33;
  localparam int EXP_W = 17;
  localparam int EXP_Q_LIMIT = 17;
  localparam int TOPK_FIELD_MAX = 15;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [31:0] EXP_STEP_Q32 = 32'd4283353945;

  typedef enum logic [1:0] {
    REG_EXPERT_COUNT = 2'd0,
    REG_TOP_K        = 2'd1,
    REG_NORMALIZE    = 2'd2,
    REG_COUNT_EN     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]         layer;
    logic signed [15:0] logit;
  } item_t;

  typedef struct packed {
    logic [5:0]  expert_index;
    logic [15:0] weight;
    logic [31:0] use_count;
    logic        last_pick;
  } result_t;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic run_init;
    logic e_clr;
    logic e_inc;
    logic max_upd;
    logic exp_mul;
    logic exp_wr;
    logic sel_cmp;
    logic sel_commit;
    logic k_clr;
    logic k_inc;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic row_close;
    logic clr_last;
    logic e_last;
    logic k_last;
    logic div_busy;
  } status_t;

  typedef logic [EXP_W-1:0] exp_rom_t [256];

  // Entry f approximates 2^(16 - f/256), built by repeated multiplication.
  function automatic exp_rom_t build_exp_rom();
    logic [95:0] acc;
    exp_rom_t    rom;
    acc = 96'd1 << 32;
    for (int f = 0; f < 256; f++) begin
      rom[f] = EXP_W'((acc + 96'h8000) >> 16);
      acc = (acc * {64'd0, EXP_STEP_Q32}) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

/* hdl/moe_rt_div.sv */
// Restoring divider, one quotient bit per cycle, with 16-bit saturation.
// Depends on moe_rt_pkg for the numerator width.
module moe_rt_div import moe_rt_pkg::*; #(
  parameter int DEN_W = 23
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic                 busy_o,
  output logic [15:0]          quo_o
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_NUM_W-1:0] acc_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DEN_W-1:0]     den_q;
  logic [DEN_W:0]       rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q, acc_q[DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(DIV_NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // The numerator shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      acc_q <= {acc_q[DIV_NUM_W-2:0], ge};
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = (|acc_q[DIV_NUM_W-1:16]) ? 16'hFFFF : acc_q[15:0];

endmodule

/* hdl/moe_rt_dp.sv */
// Router datapath: row store, exponent table, selection, counters and result register.
// Depends on moe_rt_pkg and moe_rt_div; driven by moe_rt_ctrl through cmd_t.
module moe_rt_dp import moe_rt_pkg::*; #(
  parameter int MAX_EXPERTS = 64,
  parameter int MAX_TOPK    = 8,
  parameter int LAYERS      = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  item_t            item_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  output logic             result_valid_o,
  output result_t          result_o
);

  localparam int EW    = $clog2(MAX_EXPERTS);
  localparam int PICKS = (MAX_TOPK < TOPK_FIELD_MAX)
                         ? ((MAX_TOPK < MAX_EXPERTS) ? MAX_TOPK : MAX_EXPERTS)
                         : ((TOPK_FIELD_MAX < MAX_EXPERTS) ? TOPK_FIELD_MAX : MAX_EXPERTS);
  localparam int KW    = (PICKS > 1) ? $clog2(PICKS) : 1;
  localparam int SUM_W = EXP_W + EW;
  localparam int SLOTS = LAYERS * MAX_EXPERTS;
  localparam int CW    = $clog2(SLOTS);

  // Configuration registers.
  logic [CFG_W-1:0] ecount_q;
  logic [3:0]       topk_q;
  logic             norm_q;
  logic             cnten_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q <= CFG_W'(64);
      topk_q   <= 4'd8;
      norm_q   <= 1'b0;
      cnten_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_EXPERT_COUNT: ecount_q <= cfg_data_i;
        REG_TOP_K:        topk_q   <= cfg_data_i[3:0];
        REG_NORMALIZE:    norm_q   <= cfg_data_i[0];
        REG_COUNT_EN:     cnten_q  <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  logic [6:0] n_exp;
  logic [6:0] tk;
  logic [6:0] tk_cap;
  logic [6:0] n_pick;

  always_comb begin
    if (ecount_q == '0)                    n_exp = 7'd1;
    else if (ecount_q > 7'(MAX_EXPERTS))   n_exp = 7'(MAX_EXPERTS);
    else                                   n_exp = ecount_q;
    tk     = (topk_q == '0) ? 7'd1 : {3'd0, topk_q};
    tk_cap = (tk > 7'(MAX_TOPK)) ? 7'(MAX_TOPK) : tk;
    n_pick = (tk_cap > n_exp) ? n_exp : tk_cap;
  end

  // Row collection.
  logic [EW-1:0]      row_fill_q;
  logic [3:0]         row_layer_q;
  logic [15:0]        logit_mem [MAX_EXPERTS];
  logic signed [15:0] logit_rd_q;
  logic               row_close;

  assign row_close = 7'(row_fill_q) + 7'd1 >= n_exp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_fill_q  <= '0;
      row_layer_q <= '0;
    end else if (cmd_i.accept) begin
      if (row_fill_q == '0) row_layer_q <= item_i.layer;
      row_fill_q <= row_close ? '0 : row_fill_q + 1'b1;
    end
  end

  // Element and pick counters.
  logic [EW-1:0] e_q;
  logic [KW-1:0] k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= '0;
      k_q <= '0;
    end else begin
      if (cmd_i.e_clr)      e_q <= '0;
      else if (cmd_i.e_inc) e_q <= e_q + 1'b1;
      if (cmd_i.run_init || cmd_i.k_clr) k_q <= '0;
      else if (cmd_i.k_inc)              k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) logit_mem[row_fill_q] <= item_i.logit;
    logit_rd_q <= logit_mem[e_q];
  end

  // Maximum, then exponent per element.
  logic signed [15:0]  max_q;
  logic [33:0]         prod_q;
  logic signed [16:0]  diff;
  logic [17:0]         t;
  logic [EXP_W-1:0]    ev_new;
  logic [EXP_W-1:0]    ev_mem [MAX_EXPERTS];
  logic [EXP_W-1:0]    ev_rd_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    psum_q;

  assign diff = {max_q[15], max_q} - {logit_rd_q[15], logit_rd_q};
  assign t    = prod_q[33:16];

  always_comb begin
    if (t[17:8] >= 10'(EXP_Q_LIMIT)) ev_new = '0;
    else                             ev_new = EXP_ROM[t[7:0]] >> t[12:8];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.max_upd && (e_q == '0 || logit_rd_q > max_q)) max_q <= logit_rd_q;
    if (cmd_i.exp_mul) prod_q <= {17'd0, diff[16:0]} * {17'd0, LOG2E_Q16};
    if (cmd_i.exp_wr)  ev_mem[e_q] <= ev_new;
    ev_rd_q <= ev_mem[e_q];
  end

  // Selection passes.
  logic [MAX_EXPERTS-1:0] mask_q;
  logic                   found_q;
  logic [EW-1:0]          best_q;
  logic [EXP_W-1:0]       best_ev_q;
  logic [EW-1:0]          pick_idx_q [PICKS];
  logic [EXP_W-1:0]       pick_ev_q  [PICKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      found_q <= 1'b0;
      sum_q   <= '0;
      psum_q  <= '0;
    end else if (cmd_i.run_init) begin
      mask_q  <= '0;
      found_q <= 1'b0;
      sum_q   <= '0;
      psum_q  <= '0;
    end else begin
      if (cmd_i.exp_wr) sum_q <= sum_q + SUM_W'(ev_new);
      if (cmd_i.sel_cmp && !mask_q[e_q] && (!found_q || ev_rd_q > best_ev_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.sel_commit) begin
        mask_q[best_q] <= 1'b1;
        found_q        <= 1'b0;
        psum_q         <= psum_q + SUM_W'(best_ev_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_cmp && !mask_q[e_q] && (!found_q || ev_rd_q > best_ev_q)) begin
      best_q    <= e_q;
      best_ev_q <= ev_rd_q;
    end
    if (cmd_i.sel_commit) begin
      pick_idx_q[k_q] <= best_q;
      pick_ev_q[k_q]  <= best_ev_q;
    end
  end

  // Usage counters; a pass after reset clears them.
  logic [31:0]   cnt_mem [SLOTS];
  logic [31:0]   cnt_rd_q;
  logic [31:0]   cnt_new;
  logic [CW-1:0] clr_q;
  logic [CW-1:0] slot;
  logic          layer_ok;
  logic          k_last;

  assign layer_ok = int'(row_layer_q) < LAYERS;
  assign slot     = CW'(int'(row_layer_q) * MAX_EXPERTS + int'(pick_idx_q[k_q]));
  assign cnt_new  = (cnten_q && cnt_rd_q != '1) ? cnt_rd_q + 32'd1 : cnt_rd_q;
  assign k_last   = 7'(k_q) == n_pick - 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           clr_q <= '0;
    else if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr)                          cnt_mem[clr_q] <= '0;
    else if (cmd_i.emit && layer_ok && cnten_q) cnt_mem[slot]  <= cnt_new;
    cnt_rd_q <= cnt_mem[slot];
  end

  // Weight division.
  logic        div_busy;
  logic [15:0] quo;

  moe_rt_div #(.DEN_W(SUM_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   ({pick_ev_q[k_q], 16'd0}),
    .den_i   (norm_q ? psum_q : sum_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // Result register, shown for one cycle.
  result_t result_q;
  logic    result_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_q <= 1'b0;
    else         result_valid_q <= cmd_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_q.expert_index <= 6'(pick_idx_q[k_q]);
      result_q.weight       <= quo;
      result_q.use_count    <= layer_ok ? cnt_new : 32'd0;
      result_q.last_pick    <= k_last;
    end
  end

  assign result_valid_o     = result_valid_q;
  assign result_o           = result_q;
  assign status_o.row_close = row_close;
  assign status_o.clr_last  = clr_q == CW'(SLOTS - 1);
  assign status_o.e_last    = 7'(e_q) == n_exp - 7'd1;
  assign status_o.k_last    = k_last;
  assign status_o.div_busy  = div_busy;

endmodule

/* hdl/moe_rt_ctrl.sv */
// Router controller: sequences clearing, max, exponent, selection and output phases.
// Depends on moe_rt_pkg for the command and status structs.
module moe_rt_ctrl import moe_rt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MAX_RD, S_MAX_CMP, S_EXP_RD, S_EXP_MUL, S_EXP_WR,
    S_SEL_RD, S_SEL_CMP, S_SEL_END, S_OUT_RD, S_OUT_DIV, S_OUT_EMIT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.row_close) begin
            cmd_o.run_init = 1'b1;
            cmd_o.e_clr    = 1'b1;
            state_d        = S_MAX_RD;
          end
        end
      end
      S_MAX_RD: state_d = S_MAX_CMP;
      S_MAX_CMP: begin
        cmd_o.max_upd = 1'b1;
        if (status_i.e_last) begin
          cmd_o.e_clr = 1'b1;
          state_d     = S_EXP_RD;
        end else begin
          cmd_o.e_inc = 1'b1;
          state_d     = S_MAX_RD;
        end
      end
      S_EXP_RD: state_d = S_EXP_MUL;
      S_EXP_MUL: begin
        cmd_o.exp_mul = 1'b1;
        state_d       = S_EXP_WR;
      end
      S_EXP_WR: begin
        cmd_o.exp_wr = 1'b1;
        if (status_i.e_last) begin
          cmd_o.e_clr = 1'b1;
          state_d     = S_SEL_RD;
        end else begin
          cmd_o.e_inc = 1'b1;
          state_d     = S_EXP_RD;
        end
      end
      S_SEL_RD: state_d = S_SEL_CMP;
      S_SEL_CMP: begin
        cmd_o.sel_cmp = 1'b1;
        if (status_i.e_last) begin
          state_d = S_SEL_END;
        end else begin
          cmd_o.e_inc = 1'b1;
          state_d     = S_SEL_RD;
        end
      end
      S_SEL_END: begin
        cmd_o.sel_commit = 1'b1;
        cmd_o.e_clr      = 1'b1;
        if (status_i.k_last) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_OUT_RD;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_SEL_RD;
        end
      end
      S_OUT_RD: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_OUT_DIV;
      end
      S_OUT_DIV: begin
        if (!status_i.div_busy) state_d = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.k_last) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;

`ifndef SYNTH
  a_emit_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> !cmd_o.emit)
    else $error("results emitted on consecutive cycles");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !status_i.div_busy)
    else $error("divider started while busy");
  a_close_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.row_close) |=> state_q == S_MAX_RD)
    else $error("completed row did not start processing");
`endif

endmodule

/* hdl/moe_topk_router_core.sv */
// Top level of the top-k softmax router: controller plus datapath.
// Depends on moe_rt_pkg, moe_rt_ctrl and moe_rt_dp.
//
//   channel  direction  handshake                  payload
//   item     in         start_i & !busy_o          item_i (layer, logit)
//   result   out        result_valid_o, one cycle  result_o (index, weight, count, last)
//   config   in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// After reset, clearing all LAYERS*MAX_EXPERTS count slots (1024 by default) runs with busy_o high.
// Logits are taken one per cycle while busy_o is low; the item that completes a row of N experts
// with K picks then holds busy_o high through the serial row passes and the one-bit-per-cycle
// divider. Results cannot be stalled.
module moe_topk_router_core import moe_rt_pkg::*; #(
  parameter int MAX_EXPERTS = 64,
  parameter int MAX_TOPK    = 8,
  parameter int LAYERS      = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  item_t            item_i,
  output logic             result_valid_o,
  output result_t          result_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  moe_rt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  moe_rt_dp #(
    .MAX_EXPERTS (MAX_EXPERTS),
    .MAX_TOPK    (MAX_TOPK),
    .LAYERS      (LAYERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
